// File: sv/pi3_pkg.sv
// ----------------------------------------------------------------------------
// pi3_pkg
// Shared widths, constants, codes and types of the three-channel PI block.
// ----------------------------------------------------------------------------
`default_nettype none

package pi3_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SERVO_GAIN_BITS = 16;
    localparam int WHEEL_LIMIT     = 16800;
    localparam int SERVO_RESET     = 1700;
    localparam int STEER_BAND      = 200;

    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;
    localparam int DATA_W     = 32;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int ACC_W      = 32;
    localparam int WGAIN_W    = 24;
    localparam int SGAIN_W    = 16;
    localparam int BGAIN_W    = SGAIN_W + 1;
    localparam int PROD_W     = WGAIN_W + 1 + DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int NEXT_W     = SUM_W + 1;
    localparam int DRIVE_W    = 16;
    localparam int LIM_W      = 15;
    localparam int RULE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // boost: floor((8*g + 2) / 5) via reciprocal, exact for 19-bit operands
    localparam int              BOOST_X_W   = SGAIN_W + 3;
    localparam int              BOOST_RCP_W = 19;
    localparam int              BOOST_SHIFT = 21;
    localparam logic [BOOST_RCP_W-1:0] BOOST_RECIP = 19'd419431;

    localparam logic [CH_W-1:0] CH_WHEEL_A = 2'd0;
    localparam logic [CH_W-1:0] CH_WHEEL_B = 2'd1;
    localparam logic [CH_W-1:0] CH_SERVO   = 2'd2;
    localparam logic [CH_W-1:0] CH_NONE    = 2'd3;

    localparam logic [RULE_W-1:0] STEER_OFF = 2'd0;
    localparam logic [RULE_W-1:0] STEER_NEG = 2'd1;
    localparam logic [RULE_W-1:0] STEER_POS = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SERVO_GAIN_RESET  = 32'd38666502;
    localparam logic [LIM_W-1:0]      SERVO_FLOOR_RESET = 15'd900;
    localparam logic [LIM_W-1:0]      SERVO_CEIL_RESET  = 15'd2000;

    localparam logic signed [DATA_W-1:0] STEER_BAND_FIX  = DATA_W'(STEER_BAND) <<< FRAC_BITS;
    localparam logic signed [DATA_W-1:0] STEER_BAND_NEG  = -STEER_BAND_FIX;
    localparam logic signed [ACC_W-1:0]  SERVO_ACC_RESET = ACC_W'(SERVO_RESET) <<< FRAC_BITS;
    localparam logic signed [NEXT_W-1:0] WHEEL_HI        = NEXT_W'(WHEEL_LIMIT) <<< FRAC_BITS;
    localparam logic signed [NEXT_W-1:0] WHEEL_LO        = -WHEEL_HI;
    localparam logic signed [ACC_W-1:0]  TRUNC_BIAS      = ACC_W'((1 << FRAC_BITS) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHEEL_KP    = 3'd0,
        CFG_WHEEL_KI    = 3'd1,
        CFG_SERVO_FLOOR = 3'd2,
        CFG_SERVO_CEIL  = 3'd3,
        CFG_STEER_RULE  = 3'd4,
        CFG_SERVO_GAIN  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [WGAIN_W-1:0] wheel_kp;
        logic [WGAIN_W-1:0] wheel_ki;
        logic [LIM_W-1:0]   servo_floor;
        logic [LIM_W-1:0]   servo_ceil;
        logic [RULE_W-1:0]  steer_rule;
        logic [SGAIN_W-1:0] servo_kp;
        logic [SGAIN_W-1:0] servo_ki;
        logic [BGAIN_W-1:0] servo_kp_boost;
        logic [BGAIN_W-1:0] servo_ki_boost;
    } t_cfg;

    // beat held between the product stage and the accumulate stage
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [PROD_W-1:0] prod_p;
        logic signed [PROD_W-1:0] prod_i;
    } t_prod_beat;

    function automatic logic [BGAIN_W-1:0] boost_gain(input logic [SGAIN_W-1:0] g);
        logic [BOOST_X_W-1:0]               x;
        logic [BOOST_X_W+BOOST_RCP_W-1:0]   p;
        x = {g, 3'b000} + BOOST_X_W'(2);
        p = (BOOST_X_W + BOOST_RCP_W)'(x) * (BOOST_X_W + BOOST_RCP_W)'(BOOST_RECIP);
        return p[BOOST_SHIFT +: BGAIN_W];
    endfunction

endpackage

`default_nettype wire

// File: sv/pi3_cfg.sv
// ----------------------------------------------------------------------------
// pi3_cfg
// Configuration registers; boosted servo gains are worked out at write time.
// ----------------------------------------------------------------------------
`default_nettype none

module pi3_cfg
    import pi3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wheel_kp       <= '0;
            r_cfg.wheel_ki       <= '0;
            r_cfg.servo_floor    <= SERVO_FLOOR_RESET;
            r_cfg.servo_ceil     <= SERVO_CEIL_RESET;
            r_cfg.steer_rule     <= STEER_OFF;
            r_cfg.servo_kp       <= SERVO_GAIN_RESET[SGAIN_W-1:0];
            r_cfg.servo_ki       <= SERVO_GAIN_RESET[CFG_DATA_W-1:SGAIN_W];
            r_cfg.servo_kp_boost <= boost_gain(SERVO_GAIN_RESET[SGAIN_W-1:0]);
            r_cfg.servo_ki_boost <= boost_gain(SERVO_GAIN_RESET[CFG_DATA_W-1:SGAIN_W]);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WHEEL_KP:    r_cfg.wheel_kp    <= i_cfg_data[WGAIN_W-1:0];
                CFG_WHEEL_KI:    r_cfg.wheel_ki    <= i_cfg_data[WGAIN_W-1:0];
                CFG_SERVO_FLOOR: r_cfg.servo_floor <= i_cfg_data[LIM_W-1:0];
                CFG_SERVO_CEIL:  r_cfg.servo_ceil  <= i_cfg_data[LIM_W-1:0];
                CFG_STEER_RULE:  r_cfg.steer_rule  <= i_cfg_data[RULE_W-1:0];
                CFG_SERVO_GAIN: begin
                    // kp sits in the low half, ki in the high half
                    r_cfg.servo_kp       <= i_cfg_data[SGAIN_W-1:0];
                    r_cfg.servo_ki       <= i_cfg_data[CFG_DATA_W-1:SGAIN_W];
                    r_cfg.servo_kp_boost <= boost_gain(i_cfg_data[SGAIN_W-1:0]);
                    r_cfg.servo_ki_boost <= boost_gain(i_cfg_data[CFG_DATA_W-1:SGAIN_W]);
                end
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/pi3_err_stage.sv
// ----------------------------------------------------------------------------
// pi3_err_stage
// Error, error difference, gain selection and the two products; owns the
// per-channel prior error.
// ----------------------------------------------------------------------------
`default_nettype none

module pi3_err_stage
    import pi3_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic               i_in_valid,
    input  wire logic [CH_W-1:0]    i_channel,
    input  wire logic signed [DATA_W-1:0] i_measured,
    input  wire logic signed [DATA_W-1:0] i_setpoint,
    output logic                    o_free,
    input  wire logic               i_next_free,
    output logic                    o_valid,
    output t_prod_beat              o_beat
);

    logic signed [ERR_W-1:0]  r_prior [NUM_CH];
    logic                     r_valid;
    t_prod_beat               r_beat;

    logic                     w_load;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [ERR_W-1:0]  w_prior;
    logic signed [DIFF_W-1:0] w_diff;
    logic                     w_boost;
    logic [WGAIN_W-1:0]       w_gain_p;
    logic [WGAIN_W-1:0]       w_gain_i;
    t_prod_beat               n_beat;

    assign o_free = !r_valid || i_next_free;
    assign w_load = i_in_valid && o_free;

    always_comb begin
        case (i_channel)
            CH_WHEEL_A: w_prior = r_prior[0];
            CH_WHEEL_B: w_prior = r_prior[1];
            CH_SERVO:   w_prior = r_prior[2];
            default:    w_prior = '0;
        endcase
    end

    assign w_err  = ERR_W'(i_setpoint) - ERR_W'(i_measured);
    assign w_diff = DIFF_W'(w_err) - DIFF_W'(w_prior);

    always_comb begin
        w_boost  = 1'b0;
        w_gain_p = '0;
        w_gain_i = '0;
        case (i_channel)
            CH_WHEEL_A, CH_WHEEL_B: begin
                w_gain_p = i_cfg.wheel_kp;
                w_gain_i = i_cfg.wheel_ki;
            end
            CH_SERVO: begin
                if (i_cfg.steer_rule == STEER_NEG) begin
                    w_boost = (i_setpoint < 0) || (i_measured < STEER_BAND_NEG);
                end else begin
                    w_boost = (i_setpoint > 0) || (i_measured < STEER_BAND_FIX);
                end
                if (i_cfg.steer_rule == STEER_NEG || i_cfg.steer_rule == STEER_POS) begin
                    w_gain_p = w_boost ? WGAIN_W'(i_cfg.servo_kp_boost)
                                       : WGAIN_W'(i_cfg.servo_kp);
                    w_gain_i = w_boost ? WGAIN_W'(i_cfg.servo_ki_boost)
                                       : WGAIN_W'(i_cfg.servo_ki);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_beat.channel = i_channel;
        n_beat.prod_p  = PROD_W'($signed({1'b0, w_gain_p})) * PROD_W'(w_diff);
        n_beat.prod_i  = PROD_W'($signed({1'b0, w_gain_i})) * PROD_W'(w_err);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < NUM_CH; k++) begin
                r_prior[k] <= '0;
            end
        end else begin
            if (o_free) begin
                r_valid <= i_in_valid;
            end
            if (w_load && i_channel != CH_NONE) begin
                r_prior[i_channel] <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// File: sv/pi3_acc_stage.sv
// ----------------------------------------------------------------------------
// pi3_acc_stage
// Sum of products, floor shift, accumulate, clamp and result register; owns
// the per-channel accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module pi3_acc_stage
    import pi3_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_valid,
    input  wire t_prod_beat           i_beat,
    output logic                      o_free,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic                      o_clamped
);

    logic signed [ACC_W-1:0]   r_acc [NUM_CH];
    logic                      r_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_clamped;

    logic                      w_load;
    logic                      w_servo;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_inc;
    logic signed [ACC_W-1:0]   w_acc_old;
    logic signed [NEXT_W-1:0]  w_next;
    logic signed [NEXT_W-1:0]  w_hi;
    logic signed [NEXT_W-1:0]  w_lo;
    logic signed [NEXT_W-1:0]  w_after_hi;
    logic signed [NEXT_W-1:0]  w_clamp;
    logic                      w_hit_hi;
    logic                      w_hit_lo;
    logic signed [ACC_W-1:0]   w_acc_new;
    logic signed [ACC_W-1:0]   w_adj;
    logic signed [DRIVE_W-1:0] n_drive;
    logic                      n_clamped;

    assign o_free = !r_valid || i_ready;
    assign w_load = i_valid && o_free;

    assign w_servo = (i_beat.channel == CH_SERVO);

    always_comb begin
        case (i_beat.channel)
            CH_WHEEL_A: w_acc_old = r_acc[0];
            CH_WHEEL_B: w_acc_old = r_acc[1];
            CH_SERVO:   w_acc_old = r_acc[2];
            default:    w_acc_old = '0;
        endcase
    end

    assign w_sum  = SUM_W'(i_beat.prod_p) + SUM_W'(i_beat.prod_i);
    assign w_inc  = w_servo ? (w_sum >>> SERVO_GAIN_BITS) : (w_sum >>> FRAC_BITS);
    assign w_next = NEXT_W'(w_acc_old) + NEXT_W'(w_inc);

    assign w_hi = w_servo ? (NEXT_W'(i_cfg.servo_ceil) <<< FRAC_BITS) : WHEEL_HI;
    assign w_lo = w_servo ? (NEXT_W'(i_cfg.servo_floor) <<< FRAC_BITS) : WHEEL_LO;

    // upper limit first, so a crossed pair ends on the lower limit
    assign w_hit_hi   = w_next > w_hi;
    assign w_after_hi = w_hit_hi ? w_hi : w_next;
    assign w_hit_lo   = w_after_hi < w_lo;
    assign w_clamp    = w_hit_lo ? w_lo : w_after_hi;
    assign w_acc_new  = w_clamp[ACC_W-1:0];

    // truncate toward zero
    assign w_adj = w_acc_new + (w_acc_new[ACC_W-1] ? TRUNC_BIAS : ACC_W'(0));

    always_comb begin
        if (i_beat.channel == CH_NONE) begin
            n_drive   = '0;
            n_clamped = 1'b0;
        end else begin
            n_drive   = DRIVE_W'(w_adj >>> FRAC_BITS);
            n_clamped = w_hit_hi || w_hit_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= SERVO_ACC_RESET;
        end else begin
            if (o_free) begin
                r_valid <= i_valid;
            end
            if (w_load && i_beat.channel != CH_NONE) begin
                r_acc[i_beat.channel] <= w_acc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_valid   = r_valid;
    assign o_drive   = r_drive;
    assign o_clamped = r_clamped;

endmodule

`default_nettype wire

// File: sv/incremental_pi_three_channel.sv
// ----------------------------------------------------------------------------
// incremental_pi_three_channel
// Three velocity-form PI loops (two wheels, one steering servo) in one pipe.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready): one beat per loop update, carrying the
//   channel number, the measurement and the target (signed Q16.16).
//   Output channel (o_valid/i_ready): one beat per input beat, in order,
//   with the drive value and a flag that the accumulator hit its limit.
//   Config channel (i_cfg_valid/o_cfg_ready): always ready; write only while
//   no beat is in flight. Unknown indexes are dropped.
// Timing:
//   Three register stages (input, products, result): a beat passes the input,
//   product and result registers in turn before its result beat is offered.
//   One beat per cycle is sustained while the receiver is ready, also back to
//   back on the same channel, since the prior error is updated in the product
//   stage and the accumulator in the result stage.
// Reset: pipe empty, prior errors zero, wheel accumulators zero, servo
//   accumulator 1700.0, registers at their defaults.
// Stall: a held result stalls only the stages behind it; the input side
//   keeps taking beats until all three stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pi_three_channel
    import pi3_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [CH_W-1:0]          i_channel,
    input  wire logic signed [DATA_W-1:0] i_measured,
    input  wire logic signed [DATA_W-1:0] i_setpoint,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [DRIVE_W-1:0]     o_drive,
    output logic                          o_clamped
);

    t_cfg                     w_cfg;
    logic                     r_in_valid;
    logic [CH_W-1:0]          r_channel;
    logic signed [DATA_W-1:0] r_measured;
    logic signed [DATA_W-1:0] r_setpoint;
    logic                     w_in_free;
    logic                     w_a_free;
    logic                     w_a_valid;
    logic                     w_o_free;
    t_prod_beat               w_a_beat;

    assign o_cfg_ready = 1'b1;

    pi3_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_in_free = !r_in_valid || w_a_free;
    assign o_ready   = w_in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_in_free) begin
            r_channel  <= i_channel;
            r_measured <= i_measured;
            r_setpoint <= i_setpoint;
        end
    end

    pi3_err_stage u_err (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (r_in_valid),
        .i_channel   (r_channel),
        .i_measured  (r_measured),
        .i_setpoint  (r_setpoint),
        .o_free      (w_a_free),
        .i_next_free (w_o_free),
        .o_valid     (w_a_valid),
        .o_beat      (w_a_beat)
    );

    pi3_acc_stage u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (w_a_valid),
        .i_beat    (w_a_beat),
        .o_free    (w_o_free),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_drive   (o_drive),
        .o_clamped (o_clamped)
    );

endmodule

`default_nettype wire

// File: sv/pi3_checker.sv
// ----------------------------------------------------------------------------
// pi3_checker
// Port-level checks on the three-channel PI block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pi3_checker
    import pi3_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     o_ready,
    input wire logic                     o_valid,
    input wire logic                     i_ready,
    input wire logic signed [DRIVE_W-1:0] o_drive,
    input wire logic                     o_clamped
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat offered right after reset");

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_drive) && $stable(o_clamped))
        else $error("stalled result beat changed");

    // input side only backs up behind a stalled result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input refused without a stalled result");

    // a receiver that stays ready with no new beat taken drains the pipe
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ready, 1) && $past(i_ready, 2) && $past(i_ready, 3) &&
        !$past(i_valid && o_ready, 1) && !$past(i_valid && o_ready, 2) &&
        !$past(i_valid && o_ready, 3) |-> !o_valid)
        else $error("result beat appeared with no input beat behind it");

endmodule

bind incremental_pi_three_channel pi3_checker u_pi3_checker (.*);

`default_nettype wire
